// ----- design/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg: shared constants for the source line classifier
// Byte codes, line lead codes, line class codes and stream word layout.
// ----------------------------------------------------------------------------
package slc_pkg;

  // input tuser: item kind
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_EOF  = 1'b1;

  // text bytes of interest
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  // how the current line starts
  localparam logic [2:0] LEAD_BLANK     = 3'd0;  // whitespace only so far
  localparam logic [2:0] LEAD_SLASH     = 3'd1;  // first non-blank was '/', last byte
  localparam logic [2:0] LEAD_LINE_CMT  = 3'd2;  // "//"
  localparam logic [2:0] LEAD_BLOCK_CMT = 3'd3;  // "/*"
  localparam logic [2:0] LEAD_CODE      = 3'd4;

  // line class
  localparam logic [1:0] CLS_CODE    = 2'd0;
  localparam logic [1:0] CLS_COMMENT = 2'd1;
  localparam logic [1:0] CLS_BLANK   = 2'd2;

  // result word layout
  localparam int OUT_CNT_W  = 32;
  localparam int OUT_DATA_W = 264;  // 2 + 8*32 = 258 bits, padded to bytes
  localparam int OUT_USER_W = 2;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 - 8 * OUT_CNT_W;

  // output tuser bits
  localparam int USER_LINE_VALID = 0;
  localparam int USER_FILE_DONE  = 1;

endpackage

// ----- design/source_line_classifier_core.sv -----
// ----------------------------------------------------------------------------
// source_line_classifier_core: C source line splitter and classifier
// Cuts a byte stream into lines, classes each line, keeps line counters.
// ----------------------------------------------------------------------------
// Takes one C source byte (or an end-of-file marker) per cycle and sustains
// one item per clock unless a result word waits on a full output register: an
// item sits in an input register, the line state and the saturating counters
// update from it, and a result word goes to an output register.
// A word comes out only when a line ends (newline, or MAX_LINE-1 bytes) or on
// end of file; it carries the class of the finished line and all counters.
// Items that end no line pass through without needing the output side.
module source_line_classifier_core #(
  parameter int MAX_LINE    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] char_byte
  input  logic [0:0]                      in_tuser,   // [0] func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] line_class, [33:2] file_code, [65:34] file_comment,
  // [97:66] file_blank, [129:98] file_total, [161:130] all_code,
  // [193:162] all_comment, [225:194] all_blank, [257:226] all_total, zero pad
  output logic [slc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [slc_pkg::OUT_USER_W-1:0]  out_tuser   // [0] line_valid, [1] file_done
);

  localparam int LEN_W = $clog2(MAX_LINE);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LINE - 1);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t c, input logic en);
    return (en && (c != '1)) ? c + cnt_t'(1) : c;
  endfunction

  // input register
  logic       s1_valid_r;
  logic       s1_eof_r;
  logic [7:0] s1_byte_r;

  // line state
  logic             in_block_r;
  logic [LEN_W-1:0] chunk_r;
  logic [2:0]       lead_r;
  logic             star_r;
  logic             end_r;

  cnt_t f_code_r, f_cmt_r, f_blank_r, f_total_r;
  cnt_t a_code_r, a_cmt_r, a_blank_r, a_total_r;

  // output register
  logic                           out_valid_r;
  logic [slc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [slc_pkg::OUT_USER_W-1:0] out_user_r;

  logic             out_free;
  logic             s1_fire;
  logic             is_ws;
  logic             line_end;
  logic             emits;
  logic [LEN_W-1:0] chunk_inc;
  logic [2:0]       lead_nxt;
  logic             end_nxt;
  logic             star_nxt;
  logic [2:0]       fin_lead;
  logic             fin_end;
  logic             do_finish;
  logic [1:0]       fin_cls;
  logic             block_nxt;
  logic             is_code, is_cmt, is_blank;

  cnt_t f_code_nxt, f_cmt_nxt, f_blank_nxt, f_total_nxt;
  cnt_t a_code_nxt, a_cmt_nxt, a_blank_nxt, a_total_nxt;

  logic [slc_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic [slc_pkg::OUT_USER_W-1:0] out_user_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_fire;

  assign is_ws = (s1_byte_r == slc_pkg::CH_SPACE) || (s1_byte_r == slc_pkg::CH_TAB) ||
                 (s1_byte_r == slc_pkg::CH_NL);
  assign chunk_inc = chunk_r + LEN_W'(1);
  assign line_end  = (s1_byte_r == slc_pkg::CH_NL) || (chunk_inc == LEN_LAST);
  assign emits     = s1_eof_r || line_end;
  assign s1_fire   = s1_valid_r && (!emits || out_free);

  // lead tracking for a text byte
  always_comb begin
    lead_nxt = lead_r;
    case (lead_r)
      slc_pkg::LEAD_BLANK: begin
        if (!is_ws) begin
          lead_nxt = (s1_byte_r == slc_pkg::CH_SLASH) ? slc_pkg::LEAD_SLASH
                                                      : slc_pkg::LEAD_CODE;
        end
      end
      slc_pkg::LEAD_SLASH: begin
        if (s1_byte_r == slc_pkg::CH_SLASH) begin
          lead_nxt = slc_pkg::LEAD_LINE_CMT;
        end else if (s1_byte_r == slc_pkg::CH_STAR) begin
          lead_nxt = slc_pkg::LEAD_BLOCK_CMT;
        end else begin
          lead_nxt = slc_pkg::LEAD_CODE;
        end
      end
      default: lead_nxt = lead_r;
    endcase
  end

  assign end_nxt  = end_r || (star_r && (s1_byte_r == slc_pkg::CH_SLASH));
  assign star_nxt = (s1_byte_r == slc_pkg::CH_STAR);

  // end of file classes the partial line as it stands
  assign fin_lead  = s1_eof_r ? lead_r : lead_nxt;
  assign fin_end   = s1_eof_r ? end_r : end_nxt;
  assign do_finish = s1_eof_r ? (chunk_r != '0) : line_end;

  always_comb begin
    fin_cls   = slc_pkg::CLS_CODE;
    block_nxt = in_block_r;
    if (in_block_r) begin
      fin_cls   = slc_pkg::CLS_COMMENT;
      block_nxt = !fin_end;
    end else begin
      case (fin_lead)
        slc_pkg::LEAD_BLANK:    fin_cls = slc_pkg::CLS_BLANK;
        slc_pkg::LEAD_LINE_CMT: fin_cls = slc_pkg::CLS_COMMENT;
        slc_pkg::LEAD_BLOCK_CMT: begin
          fin_cls   = slc_pkg::CLS_COMMENT;
          block_nxt = !fin_end;
        end
        default: fin_cls = slc_pkg::CLS_CODE;
      endcase
    end
  end

  assign is_code  = do_finish && (fin_cls == slc_pkg::CLS_CODE);
  assign is_cmt   = do_finish && (fin_cls == slc_pkg::CLS_COMMENT);
  assign is_blank = do_finish && (fin_cls == slc_pkg::CLS_BLANK);

  assign f_code_nxt  = sat_inc(f_code_r, is_code);
  assign f_cmt_nxt   = sat_inc(f_cmt_r, is_cmt);
  assign f_blank_nxt = sat_inc(f_blank_r, is_blank);
  assign f_total_nxt = sat_inc(f_total_r, do_finish);
  assign a_code_nxt  = sat_inc(a_code_r, is_code);
  assign a_cmt_nxt   = sat_inc(a_cmt_r, is_cmt);
  assign a_blank_nxt = sat_inc(a_blank_r, is_blank);
  assign a_total_nxt = sat_inc(a_total_r, do_finish);

  assign out_data_nxt = {
    {slc_pkg::OUT_PAD_W{1'b0}},
    slc_pkg::OUT_CNT_W'(a_total_nxt), slc_pkg::OUT_CNT_W'(a_blank_nxt),
    slc_pkg::OUT_CNT_W'(a_cmt_nxt),   slc_pkg::OUT_CNT_W'(a_code_nxt),
    slc_pkg::OUT_CNT_W'(f_total_nxt), slc_pkg::OUT_CNT_W'(f_blank_nxt),
    slc_pkg::OUT_CNT_W'(f_cmt_nxt),   slc_pkg::OUT_CNT_W'(f_code_nxt),
    (do_finish ? fin_cls : slc_pkg::CLS_CODE)
  };
  assign out_user_nxt = {s1_eof_r, do_finish};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_eof_r  <= (in_tuser[0] == slc_pkg::FUNC_EOF);
      s1_byte_r <= in_tdata;
    end
  end

  // line state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_block_r <= 1'b0;
      chunk_r    <= '0;
      lead_r     <= slc_pkg::LEAD_BLANK;
      star_r     <= 1'b0;
      end_r      <= 1'b0;
      f_code_r   <= '0;
      f_cmt_r    <= '0;
      f_blank_r  <= '0;
      f_total_r  <= '0;
      a_code_r   <= '0;
      a_cmt_r    <= '0;
      a_blank_r  <= '0;
      a_total_r  <= '0;
    end else if (s1_fire) begin
      if (emits) begin
        chunk_r    <= '0;
        lead_r     <= slc_pkg::LEAD_BLANK;
        star_r     <= 1'b0;
        end_r      <= 1'b0;
        a_code_r   <= a_code_nxt;
        a_cmt_r    <= a_cmt_nxt;
        a_blank_r  <= a_blank_nxt;
        a_total_r  <= a_total_nxt;
        if (s1_eof_r) begin
          in_block_r <= 1'b0;
          f_code_r   <= '0;
          f_cmt_r    <= '0;
          f_blank_r  <= '0;
          f_total_r  <= '0;
        end else begin
          in_block_r <= block_nxt;
          f_code_r   <= f_code_nxt;
          f_cmt_r    <= f_cmt_nxt;
          f_blank_r  <= f_blank_nxt;
          f_total_r  <= f_total_nxt;
        end
      end else begin
        chunk_r <= chunk_inc;
        lead_r  <= lead_nxt;
        star_r  <= star_nxt;
        end_r   <= end_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && emits) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_fire && emits) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- design/slc_checker.sv -----
// ----------------------------------------------------------------------------
// slc_checker: port-level checks for the source line classifier
// Watches both streams for word hold, layout and per-file counter consistency.
// ----------------------------------------------------------------------------
module slc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [7:0]                      in_tdata,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [slc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [slc_pkg::OUT_USER_W-1:0]  out_tuser
);

  logic after_done_r;

  // set after a file-done word, cleared by the next word taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_done_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      after_done_r <= out_tuser[slc_pkg::USER_FILE_DONE];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input word changed while stalled");

  a_text_word_has_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[slc_pkg::USER_FILE_DONE] |-> out_tuser[slc_pkg::USER_LINE_VALID])
    else $error("text word without a completed line");

  a_file_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && after_done_r |-> out_tdata[129:98] <= 32'd1)
    else $error("per-file total not cleared after end of file");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result valid or input blocked after reset");

endmodule

bind source_line_classifier_core slc_checker u_slc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
